// ===== rtl/core/pmsc_pkg.sv =====
// ----------------------------------------------------------------------------
// pmsc_pkg
// Shared types and constants of the motor speed PID controller.
// ----------------------------------------------------------------------------
package pmsc_pkg;

  localparam int FREQ_WIDTH_DEF = 10;
  localparam int GAIN_W         = 8;
  localparam int SUM_W          = 9;
  localparam int OUT_W          = 8;
  localparam int CFG_IDX_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KI      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KD      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 3'd4;

  localparam int                TARGET_RST = 100;
  localparam logic [GAIN_W-1:0] KP_RST     = 8'd27;
  localparam logic [GAIN_W-1:0] KI_RST     = 8'd5;
  localparam logic [GAIN_W-1:0] KD_RST     = 8'd3;
  localparam logic [GAIN_W-1:0] LIMIT_RST  = 8'd60;

  localparam logic [OUT_W-1:0] OUT_MAX = 8'd255;

  // ctl / 10 for 0 <= ctl < 2560: (ctl * 3277) >> 15
  localparam int SAT_LIMIT = 2560;
  localparam int DIV_IN_W  = 12;
  localparam int DIV_RECIP = 3277;
  localparam int DIV_SHIFT = 15;
  localparam int DIV_PROD_W = 24;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [GAIN_W-1:0] limit;
  } gains_t;

endpackage

// ===== rtl/core/pmsc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pmsc_cfg_regs
// Setpoint, gain and windup limit registers behind the config write port.
// ----------------------------------------------------------------------------
module pmsc_cfg_regs import pmsc_pkg::*; #(
  parameter int FREQ_WIDTH = FREQ_WIDTH_DEF,
  parameter int CFG_DW     = (FREQ_WIDTH > GAIN_W) ? FREQ_WIDTH : GAIN_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DW-1:0]     wr_data,
  output logic [FREQ_WIDTH-1:0] target,
  output gains_t                gains
);

  logic [FREQ_WIDTH-1:0] target_r;
  gains_t                gains_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r      <= FREQ_WIDTH'(TARGET_RST);
      gains_r.kp    <= KP_RST;
      gains_r.ki    <= KI_RST;
      gains_r.kd    <= KD_RST;
      gains_r.limit <= LIMIT_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_TARGET: target_r      <= wr_data[FREQ_WIDTH-1:0];
        REG_KP:     gains_r.kp    <= wr_data[GAIN_W-1:0];
        REG_KI:     gains_r.ki    <= wr_data[GAIN_W-1:0];
        REG_KD:     gains_r.kd    <= wr_data[GAIN_W-1:0];
        REG_LIMIT:  gains_r.limit <= wr_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign target = target_r;
  assign gains  = gains_r;

endmodule

// ===== rtl/core/pmsc_err_stage.sv =====
// ----------------------------------------------------------------------------
// pmsc_err_stage
// Input register, error, clamped integral and derivative difference.
// Holds the integral and last-error state.
// ----------------------------------------------------------------------------
module pmsc_err_stage import pmsc_pkg::*; #(
  parameter int FREQ_WIDTH = FREQ_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [FREQ_WIDTH-1:0]        in_meas,
  input  logic [FREQ_WIDTH-1:0]        target,
  input  logic [GAIN_W-1:0]            limit,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [FREQ_WIDTH:0]   out_err,
  output logic signed [SUM_W-1:0]      out_sum,
  output logic signed [FREQ_WIDTH+1:0] out_diff
);

  localparam int EW = FREQ_WIDTH + 1;
  localparam int XW = FREQ_WIDTH + 2;

  logic                  a_v_r;
  logic [FREQ_WIDTH-1:0] a_meas_r;
  logic                  b_v_r;
  logic signed [EW-1:0]    b_err_r;
  logic signed [SUM_W-1:0] b_sum_r;
  logic signed [XW-1:0]    b_diff_r;
  logic signed [SUM_W-1:0] error_sum_r;
  logic signed [EW-1:0]    prev_err_r;

  logic                    a_rdy, b_rdy;
  logic signed [EW-1:0]    err;
  logic signed [XW-1:0]    sum_raw, lim, diff;
  logic signed [SUM_W-1:0] sum_nxt;

  assign b_rdy    = !b_v_r || out_ready;
  assign a_rdy    = !a_v_r || b_rdy;
  assign in_ready = a_rdy;

  always_comb begin
    err     = $signed({1'b0, target}) - $signed({1'b0, a_meas_r});
    sum_raw = $signed({{(XW-SUM_W){error_sum_r[SUM_W-1]}}, error_sum_r})
            + $signed({err[EW-1], err});
    lim     = $signed({{(XW-GAIN_W){1'b0}}, limit});
    if (sum_raw > lim) begin
      sum_nxt = lim[SUM_W-1:0];
    end else if (sum_raw < -lim) begin
      sum_nxt = XW'(-lim) >> 0 == '0 ? '0 : SUM_W'(-lim);
    end else begin
      sum_nxt = sum_raw[SUM_W-1:0];
    end
    diff = $signed({prev_err_r[EW-1], prev_err_r}) - $signed({err[EW-1], err});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      error_sum_r <= '0;
      prev_err_r  <= '0;
    end else begin
      if (a_rdy) begin
        a_v_r <= in_valid;
      end
      if (b_rdy) begin
        b_v_r <= a_v_r;
      end
      if (a_v_r && b_rdy) begin
        error_sum_r <= sum_nxt;
        prev_err_r  <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_rdy) begin
      a_meas_r <= in_meas;
    end
    if (a_v_r && b_rdy) begin
      b_err_r  <= err;
      b_sum_r  <= sum_nxt;
      b_diff_r <= diff;
    end
  end

  assign out_valid = b_v_r;
  assign out_err   = b_err_r;
  assign out_sum   = b_sum_r;
  assign out_diff  = b_diff_r;

endmodule

// ===== rtl/core/pmsc_mult_stage.sv =====
// ----------------------------------------------------------------------------
// pmsc_mult_stage
// Gain multiplies for the proportional, integral and derivative terms.
// ----------------------------------------------------------------------------
module pmsc_mult_stage import pmsc_pkg::*; #(
  parameter int FREQ_WIDTH = FREQ_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [FREQ_WIDTH:0]    in_err,
  input  logic signed [SUM_W-1:0]       in_sum,
  input  logic signed [FREQ_WIDTH+1:0]  in_diff,
  input  gains_t                        gains,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [FREQ_WIDTH+11:0] out_p,
  output logic signed [FREQ_WIDTH+11:0] out_i,
  output logic signed [FREQ_WIDTH+11:0] out_d
);

  localparam int EW = FREQ_WIDTH + 1;
  localparam int XW = FREQ_WIDTH + 2;
  localparam int CW = FREQ_WIDTH + 12;

  logic                 v_r;
  logic signed [CW-1:0] p_r, i_r, d_r;
  logic signed [CW-1:0] kp_x, ki_x, kd_x, err_x, sum_x, diff_x;
  logic                 rdy;

  assign rdy      = !v_r || out_ready;
  assign in_ready = rdy;

  always_comb begin
    kp_x   = $signed({{(CW-GAIN_W){1'b0}}, gains.kp});
    ki_x   = $signed({{(CW-GAIN_W){1'b0}}, gains.ki});
    kd_x   = $signed({{(CW-GAIN_W){1'b0}}, gains.kd});
    err_x  = $signed({{(CW-EW){in_err[EW-1]}}, in_err});
    sum_x  = $signed({{(CW-SUM_W){in_sum[SUM_W-1]}}, in_sum});
    diff_x = $signed({{(CW-XW){in_diff[XW-1]}}, in_diff});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy) begin
      p_r <= kp_x * err_x;
      i_r <= ki_x * sum_x;
      d_r <= kd_x * diff_x;
    end
  end

  assign out_valid = v_r;
  assign out_p     = p_r;
  assign out_i     = i_r;
  assign out_d     = d_r;

endmodule

// ===== rtl/core/pmsc_out_stage.sv =====
// ----------------------------------------------------------------------------
// pmsc_out_stage
// Term sum, divide by ten, saturation to 0..255, inversion, output register.
// ----------------------------------------------------------------------------
module pmsc_out_stage import pmsc_pkg::*; #(
  parameter int FREQ_WIDTH = FREQ_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [FREQ_WIDTH+11:0] in_p,
  input  logic signed [FREQ_WIDTH+11:0] in_i,
  input  logic signed [FREQ_WIDTH+11:0] in_d,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [OUT_W-1:0]              out_duty
);

  localparam int CW = FREQ_WIDTH + 12;

  logic                  s_v_r;
  logic signed [CW-1:0]  ctl_r;
  logic                  o_v_r;
  logic [OUT_W-1:0]      duty_r;

  logic                  s_rdy, o_rdy;
  logic [DIV_PROD_W-1:0] prod;
  logic [OUT_W-1:0]      quot, duty_nxt;

  assign o_rdy    = !o_v_r || !out_stall;
  assign s_rdy    = !s_v_r || o_rdy;
  assign in_ready = s_rdy;

  always_comb begin
    prod = DIV_PROD_W'(ctl_r[DIV_IN_W-1:0]) * DIV_PROD_W'(DIV_RECIP);
    quot = prod[DIV_SHIFT+OUT_W-1:DIV_SHIFT];
    if (ctl_r[CW-1]) begin
      duty_nxt = OUT_MAX;
    end else if (ctl_r[CW-2:0] >= (CW-1)'(SAT_LIMIT)) begin
      duty_nxt = '0;
    end else begin
      duty_nxt = OUT_MAX - quot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (s_rdy) begin
        s_v_r <= in_valid;
      end
      if (o_rdy) begin
        o_v_r <= s_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s_rdy) begin
      ctl_r <= in_p + in_i + in_d;
    end
    if (s_v_r && o_rdy) begin
      duty_r <= duty_nxt;
    end
  end

  assign out_valid = o_v_r;
  assign out_duty  = duty_r;

endmodule

// ===== rtl/core/pid_motor_speed_controller.sv =====
// ----------------------------------------------------------------------------
// pid_motor_speed_controller
// PID speed loop with integral clamp and inverted PWM duty output.
// ----------------------------------------------------------------------------
// One measured frequency word in, one inverted PWM duty word out. The block
// takes a new word every cycle while the output is not stalled; a result passes
// through the input register, error and integral stage, multiply stage,
// sum stage and output register. Each stage holds its word while the stage
// after it is full and stalled, so in_stall rises only once every stage is
// occupied behind a stalled output. The integral and last-error state move
// when a word leaves the input register. Setpoint, gains and windup limit reset
// to 100, 27, 5, 3 and 60 and are written through the cfg port, which is
// always ready.
module pid_motor_speed_controller import pmsc_pkg::*; #(
  parameter int FREQ_WIDTH = FREQ_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FREQ_WIDTH-1:0] in_measured_frequency,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_W-1:0]     out_pwm_duty,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [((FREQ_WIDTH > GAIN_W) ? FREQ_WIDTH : GAIN_W)-1:0] cfg_data
);

  localparam int CFG_DW = (FREQ_WIDTH > GAIN_W) ? FREQ_WIDTH : GAIN_W;
  localparam int CW     = FREQ_WIDTH + 12;

  logic [FREQ_WIDTH-1:0] target;
  gains_t                gains;
  logic                  in_ready;

  logic                         e_valid, e_ready;
  logic signed [FREQ_WIDTH:0]   e_err;
  logic signed [SUM_W-1:0]      e_sum;
  logic signed [FREQ_WIDTH+1:0] e_diff;

  logic                 m_valid, m_ready;
  logic signed [CW-1:0] m_p, m_i, m_d;

  assign cfg_ready = 1'b1;
  assign in_stall  = !in_ready;

  pmsc_cfg_regs #(.FREQ_WIDTH(FREQ_WIDTH), .CFG_DW(CFG_DW)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .target   (target),
    .gains    (gains)
  );

  pmsc_err_stage #(.FREQ_WIDTH(FREQ_WIDTH)) u_err (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_meas   (in_measured_frequency),
    .target    (target),
    .limit     (gains.limit),
    .out_valid (e_valid),
    .out_ready (e_ready),
    .out_err   (e_err),
    .out_sum   (e_sum),
    .out_diff  (e_diff)
  );

  pmsc_mult_stage #(.FREQ_WIDTH(FREQ_WIDTH)) u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (e_valid),
    .in_ready  (e_ready),
    .in_err    (e_err),
    .in_sum    (e_sum),
    .in_diff   (e_diff),
    .gains     (gains),
    .out_valid (m_valid),
    .out_ready (m_ready),
    .out_p     (m_p),
    .out_i     (m_i),
    .out_d     (m_d)
  );

  pmsc_out_stage #(.FREQ_WIDTH(FREQ_WIDTH)) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_valid),
    .in_ready  (m_ready),
    .in_p      (m_p),
    .in_i      (m_i),
    .in_d      (m_d),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_duty  (out_pwm_duty)
  );

endmodule

// ===== rtl/core/pmsc_checker.sv =====
// ----------------------------------------------------------------------------
// pmsc_checker
// Port-level checks of the speed controller, bound to the top level.
// ----------------------------------------------------------------------------
module pmsc_checker import pmsc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [OUT_W-1:0] out_pwm_duty,
  input logic             cfg_valid,
  input logic             cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_pwm_duty))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind pid_motor_speed_controller pmsc_checker u_pmsc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_pwm_duty (out_pwm_duty),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);
